### rtl/core/sct_pkg.sv
// Shared types and constants of the sphere cell tessellator.
package sct_pkg;

	localparam int FRAC_W      = 17;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 9;
	localparam int RAD_W       = 16;
	localparam int POS_W       = 17;
	localparam int CORNERS     = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		REG_RADIUS     = 2'd0,
		REG_LAT_COUNT  = 2'd1,
		REG_LONG_COUNT = 2'd2
	} reg_idx_t;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;
	localparam logic [CNT_W-1:0] COUNT_RESET  = 9'd16;

	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [2:0] corner_t;

	localparam corner_t LAST_CORNER = 3'd5;
	localparam logic [CORNERS-1:0] CORNER_DI = 6'b001110;
	localparam logic [CORNERS-1:0] CORNER_DJ = 6'b011100;

	typedef struct packed {
		frac_t u0;
		frac_t u1;
		frac_t v0;
		frac_t v1;
	} cell_frac_t;

	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [CNT_W-1:0] lat_count;
		logic [CNT_W-1:0] long_count;
	} cfg_t;

	typedef struct packed {
		logic lat_wr;
		logic long_wr;
	} cfg_wr_t;

endpackage

### rtl/core/sct_if.sv
// Handshake interfaces for cell words and vertex words.
interface sct_cell_if import sct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] lat_index;
	logic [IDX_W-1:0] long_index;

	modport source (output valid, lat_index, long_index, input ready);
	modport sink (input valid, lat_index, long_index, output ready);
endinterface

interface sct_vertex_if import sct_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	frac_t                   tex_u;
	frac_t                   tex_v;
	corner_t                 corner;
	logic                    last_vertex;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, corner, last_vertex,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, corner, last_vertex,
		output ready);
endinterface

### rtl/core/sct_recip.sv
// Bit-serial reciprocal unit computing floor(2^SHIFT / divisor).
module sct_recip #(
	parameter int NW = 9,
	parameter int SHIFT = 25,
	parameter int QW = SHIFT + 1,
	parameter logic [QW-1:0] RESET_RECIP = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] divisor,
	output logic [QW-1:0] recip,
	output logic          busy
);

	localparam int CNTW = $clog2(QW + 1);

	logic [NW-1:0]   div_q;
	logic [NW-1:0]   rem_q;
	logic [QW-1:0]   quo_q;
	logic [QW-1:0]   recip_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [NW:0]     rem_sh;
	logic [NW:0]     rem_nx;
	logic            take;

	always_comb begin
		rem_sh = {rem_q, (cnt_q == CNTW'(QW))};
		take   = rem_sh >= {1'b0, div_q};
		rem_nx = take ? rem_sh - {1'b0, div_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			recip_q <= RESET_RECIP;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q  <= 1'b0;
				recip_q <= {quo_q[QW-2:0], take};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx[NW-1:0];
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign recip = recip_q;
	assign busy  = busy_q;

endmodule

### rtl/core/sct_front.sv
// Front end: clamps cell indices and computes the four lattice fractions of a cell.
module sct_front import sct_pkg::*; #(
	parameter int MAX_DIVISIONS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	sct_cell_if.sink        cell_in,
	input  cfg_t            cfg,
	input  cfg_wr_t         cfg_wr,
	output cell_frac_t      push_data,
	output logic            push_valid,
	input  logic            push_ready
);

	localparam int NW          = $clog2(MAX_DIVISIONS + 1);
	localparam int SHIFT       = 17 + $clog2(MAX_DIVISIONS);
	localparam int QW          = SHIFT + 1;
	localparam int RESET_EFF   = (16 > MAX_DIVISIONS) ? MAX_DIVISIONS : 16;
	localparam logic [QW-1:0] RESET_RECIP = QW'((64'd1 << SHIFT) / RESET_EFF);
	localparam int PW          = NW + QW;
	localparam int RW          = FRAC_W + NW + 1;

	function automatic logic [NW-1:0] eff_count(input logic [CNT_W-1:0] c);
		if (c == '0)
			return NW'(1);
		else if (32'(c) > MAX_DIVISIONS)
			return NW'(MAX_DIVISIONS);
		else
			return NW'(c);
	endfunction

	function automatic logic [NW-1:0] clamp_idx(input logic [IDX_W-1:0] idx,
		input logic [NW-1:0] n);
		if (32'(idx) > 32'(n) - 1)
			return n - NW'(1);
		else
			return NW'(idx);
	endfunction

	function automatic frac_t est_frac(input logic [NW-1:0] a, input logic [QW-1:0] r);
		logic [PW-1:0] p;
		p = PW'(a) * PW'(r);
		return FRAC_W'(p >> (SHIFT - 16));
	endfunction

	function automatic frac_t fix_frac(input logic [NW-1:0] a, input frac_t q,
		input logic [NW-1:0] n);
		logic [RW-1:0] num;
		logic [RW-1:0] rem;
		num = RW'(a) << 16;
		rem = num - RW'(q) * RW'(n);
		return (rem >= RW'(n)) ? q + FRAC_W'(1) : q;
	endfunction

	logic [NW-1:0] lat_eff;
	logic [NW-1:0] long_eff;
	logic [QW-1:0] lat_recip;
	logic [QW-1:0] long_recip;
	logic          lat_busy;
	logic          long_busy;
	cfg_wr_t       start_q;
	logic          busy;
	logic          advance;
	logic          accept;

	logic          v_s1;
	logic [NW-1:0] a0_s1, a1_s1, b0_s1, b1_s1;
	logic          v_s2;
	logic [NW-1:0] a0_s2, a1_s2, b0_s2, b1_s2;
	frac_t         u0_s2, u1_s2, w0_s2, w1_s2;
	logic [NW-1:0] i_cl, j_cl;

	assign lat_eff  = eff_count(cfg.lat_count);
	assign long_eff = eff_count(cfg.long_count);

	sct_recip #(
		.NW(NW), .SHIFT(SHIFT), .QW(QW), .RESET_RECIP(RESET_RECIP)
	) u_lat_recip (
		.clk(clk), .arst_n(arst_n), .start(start_q.lat_wr), .divisor(lat_eff),
		.recip(lat_recip), .busy(lat_busy)
	);

	sct_recip #(
		.NW(NW), .SHIFT(SHIFT), .QW(QW), .RESET_RECIP(RESET_RECIP)
	) u_long_recip (
		.clk(clk), .arst_n(arst_n), .start(start_q.long_wr), .divisor(long_eff),
		.recip(long_recip), .busy(long_busy)
	);

	assign busy = lat_busy || long_busy || start_q.lat_wr || start_q.long_wr ||
		cfg_wr.lat_wr || cfg_wr.long_wr;
	assign advance = !v_s2 || push_ready;
	assign cell_in.ready = advance && !busy;
	assign accept = cell_in.valid && cell_in.ready;

	assign i_cl = clamp_idx(cell_in.lat_index, lat_eff);
	assign j_cl = clamp_idx(cell_in.long_index, long_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			start_q <= cfg_wr;
			if (advance) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a0_s1 <= i_cl;
			a1_s1 <= i_cl + NW'(1);
			b0_s1 <= j_cl;
			b1_s1 <= j_cl + NW'(1);
			a0_s2 <= a0_s1;
			a1_s2 <= a1_s1;
			b0_s2 <= b0_s1;
			b1_s2 <= b1_s1;
			u0_s2 <= est_frac(a0_s1, lat_recip);
			u1_s2 <= est_frac(a1_s1, lat_recip);
			w0_s2 <= est_frac(b0_s1, long_recip);
			w1_s2 <= est_frac(b1_s1, long_recip);
		end
	end

	assign push_valid   = v_s2;
	assign push_data.u0 = fix_frac(a0_s2, u0_s2, lat_eff);
	assign push_data.u1 = fix_frac(a1_s2, u1_s2, lat_eff);
	assign push_data.v0 = fix_frac(b0_s2, w0_s2, long_eff);
	assign push_data.v1 = fix_frac(b1_s2, w1_s2, long_eff);

endmodule

### rtl/core/sct_queue.sv
// Short first-word-fall-through queue between the front and back ends.
module sct_queue import sct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_frac_t push_data,
	input  logic       push_valid,
	output logic       push_ready,
	output cell_frac_t head,
	output logic       head_valid,
	input  logic       pop
);

	cell_frac_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

endmodule

### rtl/core/sct_back.sv
// Back end: walks the six corners of a cell and computes each vertex.
module sct_back import sct_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_frac_t       head,
	input  logic             head_valid,
	output logic             pop,
	input  logic [RAD_W-1:0] radius,
	sct_vertex_if.source     vertex_out
);

	localparam int D   = SINE_TABLE_DEPTH;
	localparam int AW  = $clog2(D + 1);
	localparam int PW  = $clog2(5 * D + 1);
	localparam int TMW = FRAC_W + $clog2(4 * D) + 2;
	localparam int SW  = 17;
	localparam int PXW = RAD_W + 1 + SW;
	localparam int PRW = PXW + SW;

	typedef logic [15:0] rom_t [D+1];

	typedef struct packed {
		logic [AW-1:0] addr;
		logic          neg;
	} phase_rd_t;

	function automatic rom_t build_rom();
		rom_t              rom;
		logic [63:0]       x;
		logic [63:0]       x2;
		logic [63:0]       term;
		logic signed [63:0] sum;
		logic [63:0]       val;
		for (int k = 0; k <= D; k++) begin
			x = (64'(k) * 64'd1686629713) / 64'(D);
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			for (int n = 1; n <= 10; n++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if ((n & 1) == 1)
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
			if (sum < 0)
				sum = '0;
			val = ($unsigned(sum) + 64'd16384) >> 15;
			if (val > 64'd32768)
				val = 64'd32768;
			rom[k] = 16'(val);
		end
		return rom;
	endfunction

	localparam rom_t THETA_ROM = build_rom();
	localparam rom_t PHI_ROM   = build_rom();

	function automatic phase_rd_t decode_phase(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		logic [PW-1:0] r;
		logic [1:0]    q;
		phase_rd_t     o;
		s = (p >= PW'(4 * D)) ? p - PW'(4 * D) : p;
		if (s < PW'(D)) begin
			q = 2'd0;
			r = s;
		end else if (s < PW'(2 * D)) begin
			q = 2'd1;
			r = s - PW'(D);
		end else if (s < PW'(3 * D)) begin
			q = 2'd2;
			r = s - PW'(2 * D);
		end else begin
			q = 2'd3;
			r = s - PW'(3 * D);
		end
		o.addr = q[0] ? AW'(PW'(D) - r) : AW'(r);
		o.neg  = q[1];
		return o;
	endfunction

	function automatic logic signed [SW-1:0] apply_sign(input logic [15:0] m, input logic neg);
		logic signed [SW-1:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [POS_W-1:0] round_q(input logic signed [PRW-1:0] p,
		input int sh);
		logic [PRW-1:0] mag;
		mag = p[PRW-1] ? PRW'(-p) : PRW'(p);
		mag = (mag + (PRW'(1) << (sh - 1))) >> sh;
		return POS_W'(p[PRW-1] ? -mag : mag);
	endfunction

	logic    en;
	corner_t corner_q;

	logic    v_s1;
	frac_t   u_s1, w_s1;
	corner_t corner_s1;

	logic [PW-1:0] tt, tp;
	phase_rd_t     st_rd, ct_rd, sp_rd, cp_rd;

	logic          v_s2;
	frac_t         u_s2, w_s2;
	corner_t       corner_s2;
	logic [15:0]   st_mag_s2, ct_mag_s2, sp_mag_s2, cp_mag_s2;
	logic          st_neg_s2, ct_neg_s2, sp_neg_s2, cp_neg_s2;

	logic                  v_s3;
	frac_t                 u_s3, w_s3;
	corner_t               corner_s3;
	logic signed [PXW-1:0] rc_s3, rs_s3, rz_s3;
	logic signed [SW-1:0]  st_s3;

	logic                    v_s4;
	frac_t                   u_s4, w_s4;
	corner_t                 corner_s4;
	logic signed [PRW-1:0]   px_s4, py_s4;
	logic signed [POS_W-1:0] z_s4;

	logic                    valid_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	frac_t                   tex_u_q, tex_v_q;
	corner_t                 corner_out_q;
	logic                    last_q;

	logic signed [RAD_W:0] rad_s;

	assign en  = !valid_q || vertex_out.ready;
	assign pop = en && head_valid && (corner_q == LAST_CORNER);
	assign rad_s = $signed({1'b0, radius});

	always_comb begin
		tt = PW'((TMW'(u_s1) * TMW'(4 * D) + TMW'(65536)) >> 17);
		tp = PW'((TMW'(w_s1) * TMW'(4 * D) + TMW'(32768)) >> 16);
		st_rd = decode_phase(tt);
		ct_rd = decode_phase(tt + PW'(D));
		sp_rd = decode_phase(tp);
		cp_rd = decode_phase(tp + PW'(D));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			if (head_valid)
				corner_q <= (corner_q == LAST_CORNER) ? '0 : corner_q + corner_t'(1);
			v_s1    <= head_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1      <= CORNER_DI[corner_q] ? head.u1 : head.u0;
			w_s1      <= CORNER_DJ[corner_q] ? head.v1 : head.v0;
			corner_s1 <= corner_q;

			u_s2      <= u_s1;
			w_s2      <= w_s1;
			corner_s2 <= corner_s1;
			st_mag_s2 <= THETA_ROM[st_rd.addr];
			ct_mag_s2 <= THETA_ROM[ct_rd.addr];
			sp_mag_s2 <= PHI_ROM[sp_rd.addr];
			cp_mag_s2 <= PHI_ROM[cp_rd.addr];
			st_neg_s2 <= st_rd.neg;
			ct_neg_s2 <= ct_rd.neg;
			sp_neg_s2 <= sp_rd.neg;
			cp_neg_s2 <= cp_rd.neg;

			u_s3      <= u_s2;
			w_s3      <= w_s2;
			corner_s3 <= corner_s2;
			rc_s3     <= PXW'(rad_s * apply_sign(cp_mag_s2, cp_neg_s2));
			rs_s3     <= PXW'(rad_s * apply_sign(sp_mag_s2, sp_neg_s2));
			rz_s3     <= PXW'(rad_s * apply_sign(ct_mag_s2, ct_neg_s2));
			st_s3     <= apply_sign(st_mag_s2, st_neg_s2);

			u_s4      <= u_s3;
			w_s4      <= w_s3;
			corner_s4 <= corner_s3;
			px_s4     <= PRW'(rc_s3 * st_s3);
			py_s4     <= PRW'(rs_s3 * st_s3);
			z_s4      <= round_q(PRW'(rz_s3), 15);

			pos_x_q      <= round_q(px_s4, 30);
			pos_y_q      <= round_q(py_s4, 30);
			pos_z_q      <= z_s4;
			tex_u_q      <= u_s4;
			tex_v_q      <= w_s4;
			corner_out_q <= corner_s4;
			last_q       <= corner_s4 == LAST_CORNER;
		end
	end

	assign vertex_out.valid       = valid_q;
	assign vertex_out.pos_x       = pos_x_q;
	assign vertex_out.pos_y       = pos_y_q;
	assign vertex_out.pos_z       = pos_z_q;
	assign vertex_out.tex_u       = tex_u_q;
	assign vertex_out.tex_v       = tex_v_q;
	assign vertex_out.corner      = corner_out_q;
	assign vertex_out.last_vertex = last_q;

endmodule

### rtl/core/sphere_cell_tessellator.sv
// Top level of the sphere cell tessellator with its register port.
// Each cell word passes the front end, the queue and the back end pipeline registers.
// Each cell gives six vertex words, one a cycle while vertex_out.ready holds.
// After a write to a count register, cell words are held off while the bit-serial
// reciprocal unit recomputes.
// Reset restores the register defaults and empties the pipeline and the queue.
module sphere_cell_tessellator import sct_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int MAX_DIVISIONS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	sct_cell_if.sink          cell_in,
	sct_vertex_if.source      vertex_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [RAD_W-1:0] radius_q;
	logic [CNT_W-1:0] lat_count_q;
	logic [CNT_W-1:0] long_count_q;
	reg_idx_t         reg_idx;
	logic             wr;
	cfg_t             cfg;
	cfg_wr_t          cfg_wr;
	cell_frac_t       push_data;
	logic             push_valid;
	logic             push_ready;
	cell_frac_t       head;
	logic             head_valid;
	logic             pop;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr      = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RADIUS_RESET;
			lat_count_q  <= COUNT_RESET;
			long_count_q <= COUNT_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				REG_RADIUS:     radius_q <= pwdata[RAD_W-1:0];
				REG_LAT_COUNT:  lat_count_q <= pwdata[CNT_W-1:0];
				REG_LONG_COUNT: long_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RADIUS:     prdata = DATA_W'(radius_q);
			REG_LAT_COUNT:  prdata = DATA_W'(lat_count_q);
			REG_LONG_COUNT: prdata = DATA_W'(long_count_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.radius     = radius_q;
	assign cfg.lat_count  = lat_count_q;
	assign cfg.long_count = long_count_q;
	assign cfg_wr.lat_wr  = wr && (reg_idx == REG_LAT_COUNT);
	assign cfg_wr.long_wr = wr && (reg_idx == REG_LONG_COUNT);

	sct_front #(
		.MAX_DIVISIONS(MAX_DIVISIONS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cell_in(cell_in), .cfg(cfg), .cfg_wr(cfg_wr),
		.push_data(push_data), .push_valid(push_valid), .push_ready(push_ready)
	);

	sct_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_data(push_data), .push_valid(push_valid),
		.push_ready(push_ready), .head(head), .head_valid(head_valid), .pop(pop)
	);

	sct_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid), .pop(pop),
		.radius(radius_q), .vertex_out(vertex_out)
	);

endmodule
